[rtl/ldwh_pkg.sv]
// shared types, constants and helpers for the letter/digram histogram
package ldwh_pkg;

  localparam int ALPHA      = 26;
  localparam int CNT_W      = 32;
  localparam int LET_W      = $clog2(ALPHA);
  localparam int ADDR_W     = 10;
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;

  // memory 0: digrams then word end counts
  localparam int DIG_DEPTH  = ALPHA * ALPHA;
  localparam int M0_DEPTH   = DIG_DEPTH + ALPHA;
  localparam int M0_AW      = $clog2(M0_DEPTH);
  // memory 1: letter counts then word start counts
  localparam int M1_DEPTH   = 2 * ALPHA;
  localparam int M1_AW      = $clog2(M1_DEPTH);

  // read address map
  localparam int LET_BASE   = DIG_DEPTH;
  localparam int START_BASE = LET_BASE + ALPHA;
  localparam int END_BASE   = START_BASE + ALPHA;
  localparam int TOT_BASE   = END_BASE + ALPHA;
  localparam int MAP_END    = TOT_BASE + 3;

  localparam int IN_W       = 24;
  localparam int RES_W      = ADDR_W + CNT_W;
  localparam int OUT_W      = 48;

  localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UZ = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LZ = 8'h7A;

  typedef enum logic [MODE_W-1:0] {
    MODE_TEXT    = 2'd0,
    MODE_NEWFILE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SRC_M0,
    SRC_M1,
    SRC_CONST
  } src_t;

  typedef enum logic [1:0] {
    TOT_LETTERS = 2'd0,
    TOT_WORDS   = 2'd1,
    TOT_DIGRAMS = 2'd2,
    TOT_NONE    = 2'd3
  } tot_t;

  typedef struct packed {
    logic              m0_we;
    logic [M0_AW-1:0]  m0_addr;
    logic              m1_we;
    logic [M1_AW-1:0]  m1_addr;
    logic              is_read;
    src_t              src;
    logic [ADDR_W-1:0] echo;
    logic [CNT_W-1:0]  cval;
  } op_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

endpackage

[rtl/ldwh_ram.sv]
// single-write, single-read synchronous memory with registered read data
module ldwh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ldwh_track.sv]
// word tracking, grand totals and per-beat memory operation decode
module ldwh_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ldwh_pkg::MODE_W-1:0] mode,
  input  logic [ldwh_pkg::BYTE_W-1:0] byte_value,
  input  logic [ldwh_pkg::ADDR_W-1:0] read_address,
  output ldwh_pkg::op_t               op
);

  logic [ldwh_pkg::LET_W-1:0] prev_r, prev_nxt;
  logic [ldwh_pkg::LET_W-1:0] first_r, first_nxt;
  logic [ldwh_pkg::LET_W-1:0] final_r, final_nxt;
  logic                       inside_r, inside_nxt;
  logic                       have_last_r, have_last_nxt;
  logic [ldwh_pkg::CNT_W-1:0] tot_let_r, tot_let_nxt;
  logic [ldwh_pkg::CNT_W-1:0] tot_word_r, tot_word_nxt;
  logic [ldwh_pkg::CNT_W-1:0] tot_dig_r, tot_dig_nxt;

  logic                       is_letter;
  logic [ldwh_pkg::LET_W-1:0] idx;
  logic [ldwh_pkg::LET_W-1:0] dig_hi;
  ldwh_pkg::tot_t             tsel;

  // letter decode, case folded
  always_comb begin
    is_letter = 1'b0;
    idx       = '0;
    priority if (byte_value >= ldwh_pkg::CHAR_UA && byte_value <= ldwh_pkg::CHAR_UZ) begin
      is_letter = 1'b1;
      idx       = ldwh_pkg::LET_W'(byte_value - ldwh_pkg::CHAR_UA);
    end else if (byte_value >= ldwh_pkg::CHAR_LA && byte_value <= ldwh_pkg::CHAR_LZ) begin
      is_letter = 1'b1;
      idx       = ldwh_pkg::LET_W'(byte_value - ldwh_pkg::CHAR_LA);
    end else begin
      is_letter = 1'b0;
    end
  end

  assign dig_hi = inside_r ? prev_r : final_r;
  assign tsel   = ldwh_pkg::tot_t'(2'(read_address - ldwh_pkg::ADDR_W'(ldwh_pkg::TOT_BASE)));

  always_comb begin
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    final_nxt     = final_r;
    inside_nxt    = inside_r;
    have_last_nxt = have_last_r;
    tot_let_nxt   = tot_let_r;
    tot_word_nxt  = tot_word_r;
    tot_dig_nxt   = tot_dig_r;
    op            = '0;
    op.src        = ldwh_pkg::SRC_CONST;
    op.echo       = read_address;
    unique case (ldwh_pkg::mode_t'(mode))
      ldwh_pkg::MODE_TEXT: begin
        if (is_letter) begin
          // digram with the previous letter, or across the word gap
          op.m0_we   = inside_r | have_last_r;
          op.m0_addr = ldwh_pkg::M0_AW'(dig_hi) * ldwh_pkg::M0_AW'(ldwh_pkg::ALPHA)
                       + ldwh_pkg::M0_AW'(idx);
          op.m1_we   = 1'b1;
          op.m1_addr = ldwh_pkg::M1_AW'(idx);
          if (inside_r | have_last_r) begin
            tot_dig_nxt = ldwh_pkg::sat_inc(tot_dig_r);
          end
          tot_let_nxt = ldwh_pkg::sat_inc(tot_let_r);
          if (!inside_r) begin
            first_nxt = idx;
          end
          prev_nxt   = idx;
          inside_nxt = 1'b1;
        end else if (inside_r) begin
          // separator closes the word: end count in memory 0, start in memory 1
          op.m0_we      = 1'b1;
          op.m0_addr    = ldwh_pkg::M0_AW'(ldwh_pkg::DIG_DEPTH) + ldwh_pkg::M0_AW'(prev_r);
          op.m1_we      = 1'b1;
          op.m1_addr    = ldwh_pkg::M1_AW'(ldwh_pkg::ALPHA) + ldwh_pkg::M1_AW'(first_r);
          tot_word_nxt  = ldwh_pkg::sat_inc(tot_word_r);
          final_nxt     = prev_r;
          have_last_nxt = 1'b1;
          inside_nxt    = 1'b0;
        end
      end
      ldwh_pkg::MODE_NEWFILE: begin
        prev_nxt      = '0;
        first_nxt     = '0;
        final_nxt     = '0;
        inside_nxt    = 1'b0;
        have_last_nxt = 1'b0;
      end
      ldwh_pkg::MODE_READ: begin
        op.is_read = 1'b1;
        priority if (read_address < ldwh_pkg::ADDR_W'(ldwh_pkg::DIG_DEPTH)) begin
          op.src     = ldwh_pkg::SRC_M0;
          op.m0_addr = ldwh_pkg::M0_AW'(read_address);
        end else if (read_address < ldwh_pkg::ADDR_W'(ldwh_pkg::END_BASE)) begin
          // letters and starts sit back to back in memory 1
          op.src     = ldwh_pkg::SRC_M1;
          op.m1_addr = ldwh_pkg::M1_AW'(read_address - ldwh_pkg::ADDR_W'(ldwh_pkg::LET_BASE));
        end else if (read_address < ldwh_pkg::ADDR_W'(ldwh_pkg::TOT_BASE)) begin
          op.src     = ldwh_pkg::SRC_M0;
          op.m0_addr = ldwh_pkg::M0_AW'(read_address
                       - ldwh_pkg::ADDR_W'(ldwh_pkg::END_BASE - ldwh_pkg::DIG_DEPTH));
        end else if (read_address < ldwh_pkg::ADDR_W'(ldwh_pkg::MAP_END)) begin
          unique case (tsel)
            ldwh_pkg::TOT_LETTERS: op.cval = tot_let_r;
            ldwh_pkg::TOT_WORDS:   op.cval = tot_word_r;
            ldwh_pkg::TOT_DIGRAMS: op.cval = tot_dig_r;
            default:               op.cval = '0;
          endcase
        end else begin
          op.cval = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      first_r     <= '0;
      final_r     <= '0;
      inside_r    <= 1'b0;
      have_last_r <= 1'b0;
      tot_let_r   <= '0;
      tot_word_r  <= '0;
      tot_dig_r   <= '0;
    end else if (accept) begin
      prev_r      <= prev_nxt;
      first_r     <= first_nxt;
      final_r     <= final_nxt;
      inside_r    <= inside_nxt;
      have_last_r <= have_last_nxt;
      tot_let_r   <= tot_let_nxt;
      tot_word_r  <= tot_word_nxt;
      tot_dig_r   <= tot_dig_nxt;
    end
  end

endmodule

[rtl/ldwh_outbuf.sv]
// two-entry result buffer: output register plus skid stage
module ldwh_outbuf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [ldwh_pkg::RES_W-1:0] push_data,
  output logic                       full,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ldwh_pkg::RES_W-1:0] out_data
);

  logic                       out_v_r, out_v_nxt;
  logic                       skid_v_r, skid_v_nxt;
  logic [ldwh_pkg::RES_W-1:0] out_d_r, out_d_nxt;
  logic [ldwh_pkg::RES_W-1:0] skid_d_r, skid_d_nxt;
  logic                       pop;

  assign pop        = out_v_r & out_tready;
  assign full       = skid_v_r;
  assign out_tvalid = out_v_r;
  assign out_data   = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_data;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      if (!out_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

[rtl/letter_digram_word_boundary_histogram.sv]
// top level: letter, digram and word boundary histogram over a text byte stream
//
//  beat group | direction | tdata fields (low bit up)              | tuser
//  in_        | slave     | byte_value[7:0], read_address[17:8]    | mode[1:0]
//  out_       | master    | read_back_address[9:0], count_value[41:10] | none
//
//  each beat runs as accept and memory read, then modify and write back;
//  the memory port pair (one read, one write per memory) forces that split
//  after reset a clearing pass writes zero over memory 0 (702 entries) and memory 1;
//  no beat is accepted until it is done
//  results wait in a two-entry buffer, so a stalled out_ side holds off in_
//  only once both entries are full
module letter_digram_word_boundary_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_value[7:0], read_address[17:8], zero fill
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_back_address[9:0], count_value[41:10], zero fill
);

  logic                       accept;
  ldwh_pkg::op_t              op;
  ldwh_pkg::op_t              stg_r;
  logic                       busy_r;

  // clearing pass after reset
  logic                       clr_active_r;
  logic [ldwh_pkg::M0_AW-1:0] clr_addr_r;

  // memory ports
  logic                       m0_we, m1_we;
  logic [ldwh_pkg::M0_AW-1:0] m0_waddr;
  logic [ldwh_pkg::M1_AW-1:0] m1_waddr;
  logic [ldwh_pkg::CNT_W-1:0] m0_wdata, m1_wdata;
  logic [ldwh_pkg::CNT_W-1:0] m0_rdata, m1_rdata;

  // result path
  logic                       push;
  logic [ldwh_pkg::RES_W-1:0] push_data;
  logic [ldwh_pkg::CNT_W-1:0] rd_value;
  logic                       ob_full;
  logic [ldwh_pkg::RES_W-1:0] ob_data;

  // one beat in flight at most; a beat is taken only with a free result slot
  assign in_tready = ~busy_r & ~clr_active_r & ~ob_full;
  assign accept    = in_tvalid & in_tready;

  ldwh_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .mode         (in_tuser),
    .byte_value   (in_tdata[7:0]),
    .read_address (in_tdata[17:8]),
    .op           (op)
  );

  // write-back cycle of a beat: op held for write back and result selection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == ldwh_pkg::M0_AW'(ldwh_pkg::M0_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + ldwh_pkg::M0_AW'(1);
    end
  end

  // write side: zero fill during the clearing pass, else saturating increment
  always_comb begin
    if (clr_active_r) begin
      m0_we    = 1'b1;
      m0_waddr = clr_addr_r;
      m0_wdata = '0;
      m1_we    = (clr_addr_r < ldwh_pkg::M0_AW'(ldwh_pkg::M1_DEPTH));
      m1_waddr = ldwh_pkg::M1_AW'(clr_addr_r);
      m1_wdata = '0;
    end else begin
      m0_we    = busy_r & stg_r.m0_we;
      m0_waddr = stg_r.m0_addr;
      m0_wdata = ldwh_pkg::sat_inc(m0_rdata);
      m1_we    = busy_r & stg_r.m1_we;
      m1_waddr = stg_r.m1_addr;
      m1_wdata = ldwh_pkg::sat_inc(m1_rdata);
    end
  end

  // digrams and word ends
  ldwh_ram #(
    .WIDTH (ldwh_pkg::CNT_W),
    .DEPTH (ldwh_pkg::M0_DEPTH),
    .AW    (ldwh_pkg::M0_AW)
  ) u_mem0 (
    .clk   (clk),
    .we    (m0_we),
    .waddr (m0_waddr),
    .wdata (m0_wdata),
    .re    (accept),
    .raddr (op.m0_addr),
    .rdata (m0_rdata)
  );

  // letters and word starts
  ldwh_ram #(
    .WIDTH (ldwh_pkg::CNT_W),
    .DEPTH (ldwh_pkg::M1_DEPTH),
    .AW    (ldwh_pkg::M1_AW)
  ) u_mem1 (
    .clk   (clk),
    .we    (m1_we),
    .waddr (m1_waddr),
    .wdata (m1_wdata),
    .re    (accept),
    .raddr (op.m1_addr),
    .rdata (m1_rdata)
  );

  always_comb begin
    unique case (stg_r.src)
      ldwh_pkg::SRC_M0: rd_value = m0_rdata;
      ldwh_pkg::SRC_M1: rd_value = m1_rdata;
      default:          rd_value = stg_r.cval;
    endcase
  end

  assign push      = busy_r & stg_r.is_read;
  assign push_data = {rd_value, stg_r.echo};

  ldwh_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (ob_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (ob_data)
  );

  assign out_tdata = ldwh_pkg::OUT_W'(ob_data);

  // a beat always occupies the write-back cycle right after its accept
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("write-back cycle missing after accept");

  // no accept while a write back is pending, so no same-entry overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !accept)
    else $error("beat accepted during write back");

  // a result never arrives when both buffer entries are full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !ob_full)
    else $error("result buffer overflow");

  // no memory traffic from beats during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!accept && !busy_r))
    else $error("beat during clearing pass");

endmodule
